// ===== design/tkv_pkg.sv =====
package tkv_pkg;

  localparam int unsigned KEY_COUNT    = 1024;
  localparam int unsigned THREAD_SLOTS = 160;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned TID_W    = 22;
  localparam int unsigned KEY_IN_W = 16;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned NEWKEY_W = 10;

  typedef enum logic [FUNC_W-1:0] {
    FN_CREATE = 2'd0,
    FN_DELETE = 2'd1,
    FN_GET    = 2'd2,
    FN_SET    = 2'd3
  } tkv_func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_KEY   = 2'd1,
    ST_EXHAUSTED = 2'd2
  } tkv_status_e;

  // Flags that travel with a lookup from one slot cell to the next.
  typedef struct packed {
    logic valid;
    logic hit;
    logic free;
  } tkv_scan_t;

endpackage

// ===== design/tkv_cell.sv =====
module tkv_cell #(
  parameter int unsigned SLOT_W = $clog2(tkv_pkg::THREAD_SLOTS),
  parameter int unsigned IDX    = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  tkv_pkg::tkv_scan_t       scan_i,
  input  logic [tkv_pkg::TID_W-1:0] tid_i,
  input  logic [SLOT_W-1:0]        hit_idx_i,
  input  logic [SLOT_W-1:0]        free_idx_i,
  output tkv_pkg::tkv_scan_t       scan_o,
  output logic [tkv_pkg::TID_W-1:0] tid_o,
  output logic [SLOT_W-1:0]        hit_idx_o,
  output logic [SLOT_W-1:0]        free_idx_o,
  input  logic                     claim_en_i,
  input  logic [SLOT_W-1:0]        claim_idx_i,
  input  logic [tkv_pkg::TID_W-1:0] claim_tid_i
);

  logic [tkv_pkg::TID_W-1:0] id_q, id_d;
  tkv_pkg::tkv_scan_t        scan_q, scan_d;
  logic [tkv_pkg::TID_W-1:0] tid_q;
  logic [SLOT_W-1:0]         hit_idx_q, hit_idx_d;
  logic [SLOT_W-1:0]         free_idx_q, free_idx_d;
  logic                      match, empty;

  assign match = (id_q == tid_i);
  assign empty = (id_q == '0);

  // The earliest matching slot and the earliest free slot win.
  always_comb begin
    scan_d.valid = scan_i.valid;
    scan_d.hit   = scan_i.hit | match;
    scan_d.free  = scan_i.free | empty;
    hit_idx_d    = scan_i.hit ? hit_idx_i : SLOT_W'(IDX);
    free_idx_d   = scan_i.free ? free_idx_i : SLOT_W'(IDX);
    id_d         = id_q;
    if (claim_en_i && (claim_idx_i == SLOT_W'(IDX))) begin
      id_d = claim_tid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_q   <= '0;
      scan_q <= '0;
    end else begin
      id_q   <= id_d;
      scan_q <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tid_q      <= tid_i;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
  end

  assign scan_o     = scan_q;
  assign tid_o      = tid_q;
  assign hit_idx_o  = hit_idx_q;
  assign free_idx_o = free_idx_q;

endmodule

// ===== design/thread_key_value_table_core.sv =====
// Per-thread key/value table. A create passes from the transfer through the
// finish state into the output register, as does any call with a key at or
// above KEY_COUNT. Get and set walk the lookup through the chain of slot
// cells, one slot cell per cycle, and then access the value memory. Delete
// clears the key in every slot through the single write port of the value
// memory, one slot per cycle. After reset the value memory is cleared, during
// which no input transfer is taken. One call is worked on at a time; a
// finished result waits in the output register while the next call is taken.
module thread_key_value_table_core #(
  parameter int unsigned KEY_COUNT    = tkv_pkg::KEY_COUNT,
  parameter int unsigned THREAD_SLOTS = tkv_pkg::THREAD_SLOTS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tkv_pkg::FUNC_W-1:0]    func_i,
  input  logic [tkv_pkg::TID_W-1:0]     thread_id_i,
  input  logic [tkv_pkg::KEY_IN_W-1:0]  table_key_i,
  input  logic [tkv_pkg::VALUE_W-1:0]   write_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tkv_pkg::STATUS_W-1:0]  status_o,
  output logic [tkv_pkg::VALUE_W-1:0]   read_value_o,
  output logic [tkv_pkg::NEWKEY_W-1:0]  new_key_o
);

  localparam int unsigned SLOT_W    = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int unsigned KEY_W     = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int unsigned CNT_W     = $clog2(KEY_COUNT + 1);
  localparam int unsigned MEM_DEPTH = THREAD_SLOTS * KEY_COUNT;
  localparam int unsigned ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_SCAN   = 6'b000100,
    S_DELETE = 6'b001000,
    S_ACCESS = 6'b010000,
    S_FINISH = 6'b100000
  } state_e;

  state_e                       state_q, state_d;
  logic [ADDR_W-1:0]            addr_q, addr_d;
  logic [SLOT_W-1:0]            slot_cnt_q, slot_cnt_d;
  logic [CNT_W-1:0]             key_cnt_q, key_cnt_d;
  tkv_pkg::tkv_func_e           func_q, func_d;
  logic [tkv_pkg::TID_W-1:0]    tid_q, tid_d;
  logic [tkv_pkg::KEY_IN_W-1:0] key_q, key_d;
  logic [tkv_pkg::VALUE_W-1:0]  wval_q, wval_d;
  tkv_pkg::tkv_status_e         rs_status_q, rs_status_d;
  logic [tkv_pkg::NEWKEY_W-1:0] rs_newkey_q, rs_newkey_d;
  logic                         rs_get_q, rs_get_d;
  logic                         out_valid_q, out_valid_d;
  logic [tkv_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic [tkv_pkg::VALUE_W-1:0]  out_value_q, out_value_d;
  logic [tkv_pkg::NEWKEY_W-1:0] out_newkey_q, out_newkey_d;

  logic [tkv_pkg::VALUE_W-1:0]  mem [MEM_DEPTH];
  logic [tkv_pkg::VALUE_W-1:0]  rd_q;
  logic                         mem_we;
  logic [tkv_pkg::VALUE_W-1:0]  mem_wdata;

  tkv_pkg::tkv_scan_t           scan_w     [THREAD_SLOTS+1];
  logic [tkv_pkg::TID_W-1:0]    tid_w      [THREAD_SLOTS+1];
  logic [SLOT_W-1:0]            hit_idx_w  [THREAD_SLOTS+1];
  logic [SLOT_W-1:0]            free_idx_w [THREAD_SLOTS+1];

  tkv_pkg::tkv_scan_t           tail;
  logic                         claim_en;
  logic [SLOT_W-1:0]            slot_sel;
  logic                         in_xfer;
  logic                         key_bad;
  tkv_pkg::tkv_func_e           func_in;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign func_in    = tkv_pkg::tkv_func_e'(func_i);
  assign key_bad    = ({1'b0, table_key_i} >= (tkv_pkg::KEY_IN_W + 1)'(KEY_COUNT));

  assign scan_w[0].valid = in_xfer && !key_bad
                           && ((func_in == tkv_pkg::FN_GET) || (func_in == tkv_pkg::FN_SET));
  assign scan_w[0].hit   = 1'b0;
  assign scan_w[0].free  = 1'b0;
  assign tid_w[0]        = thread_id_i;
  assign hit_idx_w[0]    = '0;
  assign free_idx_w[0]   = '0;

  assign tail     = scan_w[THREAD_SLOTS];
  assign claim_en = (state_q == S_SCAN) && tail.valid && !tail.hit && tail.free;

  for (genvar g = 0; g < THREAD_SLOTS; g++) begin : g_cell
    tkv_cell #(
      .SLOT_W(SLOT_W),
      .IDX   (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .scan_i     (scan_w[g]),
      .tid_i      (tid_w[g]),
      .hit_idx_i  (hit_idx_w[g]),
      .free_idx_i (free_idx_w[g]),
      .scan_o     (scan_w[g+1]),
      .tid_o      (tid_w[g+1]),
      .hit_idx_o  (hit_idx_w[g+1]),
      .free_idx_o (free_idx_w[g+1]),
      .claim_en_i (claim_en),
      .claim_idx_i(free_idx_w[THREAD_SLOTS]),
      .claim_tid_i(tid_q)
    );
  end

  always_comb begin
    priority if (tail.hit) begin
      slot_sel = hit_idx_w[THREAD_SLOTS];
    end else if (tail.free) begin
      slot_sel = free_idx_w[THREAD_SLOTS];
    end else begin
      slot_sel = '0;
    end
  end

  assign mem_we    = (state_q == S_CLEAR) || (state_q == S_DELETE)
                     || ((state_q == S_ACCESS) && (func_q == tkv_pkg::FN_SET));
  assign mem_wdata = (state_q == S_ACCESS) ? wval_q : '0;

  always_comb begin
    state_d      = state_q;
    addr_d       = addr_q;
    slot_cnt_d   = slot_cnt_q;
    key_cnt_d    = key_cnt_q;
    func_d       = func_q;
    tid_d        = tid_q;
    key_d        = key_q;
    wval_d       = wval_q;
    rs_status_d  = rs_status_q;
    rs_newkey_d  = rs_newkey_q;
    rs_get_d     = rs_get_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_newkey_d = out_newkey_q;

    unique case (state_q)
      S_CLEAR: begin
        addr_d = addr_q + ADDR_W'(1);
        if (addr_q == ADDR_W'(MEM_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          func_d      = func_in;
          tid_d       = thread_id_i;
          key_d       = table_key_i;
          wval_d      = write_value_i;
          rs_status_d = tkv_pkg::ST_OK;
          rs_newkey_d = '0;
          rs_get_d    = 1'b0;
          priority if (func_in == tkv_pkg::FN_CREATE) begin
            if (key_cnt_q >= CNT_W'(KEY_COUNT)) begin
              rs_status_d = tkv_pkg::ST_EXHAUSTED;
            end else begin
              rs_newkey_d = tkv_pkg::NEWKEY_W'(key_cnt_q);
              key_cnt_d   = key_cnt_q + CNT_W'(1);
            end
            state_d = S_FINISH;
          end else if (key_bad) begin
            rs_status_d = tkv_pkg::ST_BAD_KEY;
            state_d     = S_FINISH;
          end else if (func_in == tkv_pkg::FN_DELETE) begin
            addr_d     = ADDR_W'(table_key_i[KEY_W-1:0]);
            slot_cnt_d = '0;
            state_d    = S_DELETE;
          end else begin
            rs_get_d = (func_in == tkv_pkg::FN_GET);
            state_d  = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (tail.valid) begin
          addr_d  = ADDR_W'(slot_sel) * ADDR_W'(KEY_COUNT) + ADDR_W'(key_q[KEY_W-1:0]);
          state_d = S_ACCESS;
        end
      end
      S_DELETE: begin
        addr_d     = addr_q + ADDR_W'(KEY_COUNT);
        slot_cnt_d = slot_cnt_q + SLOT_W'(1);
        if (slot_cnt_q == SLOT_W'(THREAD_SLOTS - 1)) begin
          state_d = S_FINISH;
        end
      end
      S_ACCESS: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = rs_status_q;
          out_value_d  = rs_get_q ? rd_q : '0;
          out_newkey_d = rs_newkey_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      addr_q      <= '0;
      slot_cnt_q  <= '0;
      key_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      slot_cnt_q  <= slot_cnt_d;
      key_cnt_q   <= key_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    tid_q        <= tid_d;
    key_q        <= key_d;
    wval_q       <= wval_d;
    rs_status_q  <= rs_status_d;
    rs_newkey_q  <= rs_newkey_d;
    rs_get_q     <= rs_get_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_newkey_q <= out_newkey_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr_q] <= mem_wdata;
    end
    rd_q <= mem[addr_q];
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign read_value_o = out_value_q;
  assign new_key_o    = out_newkey_q;

  a_result_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_FINISH))
    else $error("Result appeared without a finished call.");

  a_tail_only_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |-> (state_q == S_SCAN))
    else $error("Lookup left the slot chain outside of a scan.");

  a_key_counter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_cnt_q <= CNT_W'(KEY_COUNT))
    else $error("Key counter passed the key count.");

  a_no_write_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_IDLE) || (state_q == S_FINISH)) |-> !mem_we)
    else $error("Value memory written outside of a call.");

endmodule

// ===== bench/thread_key_value_table_core_tb.sv =====
module thread_key_value_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    tkv_pkg::tkv_func_e                func;
    logic [tkv_pkg::TID_W-1:0]         tid;
    logic [tkv_pkg::KEY_IN_W-1:0]      key;
    logic [tkv_pkg::VALUE_W-1:0]       wval;
    int                                phase;
    bit                                drain;
  } call_t;

  typedef struct packed {
    tkv_pkg::tkv_status_e              status;
    logic [tkv_pkg::VALUE_W-1:0]       rval;
    logic [tkv_pkg::NEWKEY_W-1:0]      nkey;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #10 clk = ~clk;

  call_t offered = '0;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready;
  logic out_valid;
  logic [tkv_pkg::STATUS_W-1:0] status;
  logic [tkv_pkg::VALUE_W-1:0] read_value;
  logic [tkv_pkg::NEWKEY_W-1:0] new_key;

  thread_key_value_table_core u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .func_i       (offered.func),
    .thread_id_i  (offered.tid),
    .table_key_i  (offered.key),
    .write_value_i(offered.wval),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .status_o     (status),
    .read_value_o (read_value),
    .new_key_o    (new_key)
  );

  // Predicted table contents, kept in step with accepted calls.
  bit [$clog2(tkv_pkg::KEY_COUNT):0] key_ctr = '0;
  bit [tkv_pkg::TID_W-1:0]           slot_owner [tkv_pkg::THREAD_SLOTS];
  bit [tkv_pkg::VALUE_W-1:0]         slot_val [tkv_pkg::THREAD_SLOTS][tkv_pkg::KEY_COUNT];

  call_t  queued_calls [$];
  reply_t owed_replies [$];

  int send_idle [4] = '{0, 65, 0, 30};
  int recv_stall [4] = '{0, 0, 65, 30};
  int cur_phase = 0;
  int errors = 0;
  int accepted_calls = 0;
  bit in_fire = 1'b0;
  bit hold_off = 1'b0;

  function automatic reply_t apply_call(call_t c);
    reply_t r;
    int     slot;
    int     free_at;
    bit     hit;
    r.status = tkv_pkg::ST_OK;
    r.rval   = '0;
    r.nkey   = '0;
    if (c.func == tkv_pkg::FN_CREATE) begin
      if (key_ctr >= tkv_pkg::KEY_COUNT) begin
        r.status = tkv_pkg::ST_EXHAUSTED;
      end else begin
        r.nkey  = key_ctr[tkv_pkg::NEWKEY_W-1:0];
        key_ctr = key_ctr + 1'b1;
      end
    end else if (c.key >= tkv_pkg::KEY_COUNT) begin
      r.status = tkv_pkg::ST_BAD_KEY;
    end else if (c.func == tkv_pkg::FN_DELETE) begin
      for (int s = 0; s < tkv_pkg::THREAD_SLOTS; s++) slot_val[s][c.key] = '0;
    end else begin
      // An owning slot wins; otherwise the lowest free slot is claimed, and
      // a full table falls back to sharing slot zero.
      hit     = 1'b0;
      free_at = -1;
      slot    = 0;
      for (int s = 0; s < tkv_pkg::THREAD_SLOTS && !hit; s++) begin
        if (slot_owner[s] == c.tid) begin
          slot = s;
          hit  = 1'b1;
        end else if (slot_owner[s] == '0 && free_at < 0) begin
          free_at = s;
        end
      end
      if (!hit && free_at >= 0) begin
        slot = free_at;
        slot_owner[free_at] = c.tid;
      end
      if (c.func == tkv_pkg::FN_GET) begin
        r.rval = slot_val[slot][c.key];
      end else begin
        slot_val[slot][c.key] = c.wval;
      end
    end
    return r;
  endfunction

  task automatic add_call(tkv_pkg::tkv_func_e f, logic [tkv_pkg::TID_W-1:0] t,
                          logic [tkv_pkg::KEY_IN_W-1:0] k,
                          logic [tkv_pkg::VALUE_W-1:0] v);
    call_t c;
    c       = '0;
    c.func  = f;
    c.tid   = t;
    c.key   = k;
    c.wval  = v;
    queued_calls.push_back(c);
  endtask

  always @(negedge clk) begin : drive_proc
    call_t nxt;
    bit    go;
    if (rst_n) begin
      if (!in_valid || in_fire) begin
        go = queued_calls.size() != 0;
        if (go && queued_calls[0].drain) go = owed_replies.size() == 0;
        if (go) go = $urandom_range(99) >= send_idle[queued_calls[0].phase];
        if (go) begin
          nxt       = queued_calls.pop_front();
          cur_phase = nxt.phase;
          offered  <= nxt;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= !hold_off && ($urandom_range(99) >= recv_stall[cur_phase]);
    end
  end

  always @(posedge clk) begin : watch_proc
    reply_t want;
    if (!rst_n) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        owed_replies.push_back(apply_call(offered));
        accepted_calls <= accepted_calls + 1;
      end
      if (out_valid && out_ready) begin
        if (owed_replies.size() == 0) begin
          $display("%0t: result with none expected, status %0d read_value %h new_key %0d",
                   $time, status, read_value, new_key);
          errors++;
        end else begin
          want = owed_replies.pop_front();
          if (status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, status);
            errors++;
          end
          if (read_value !== want.rval) begin
            $display("%0t: read_value expected %h, got %h", $time, want.rval, read_value);
            errors++;
          end
          if (new_key !== want.nkey) begin
            $display("%0t: new_key expected %0d, got %0d", $time, want.nkey, new_key);
            errors++;
          end
        end
      end
    end
  end

  // The receiver holds off for a long stretch while the sender keeps offering.
  initial begin
    while (accepted_calls < 300) @(posedge clk);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    #100ms;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    call_t                     c;
    int                        roll;
    int                        kroll;
    int                        ph;
    logic [tkv_pkg::TID_W-1:0] hot_tid [8];
    int                        create_pct [4];

    create_pct = '{72, 62, 62, 72};

    add_call(tkv_pkg::FN_GET, 22'd5, 16'd0, '0);
    add_call(tkv_pkg::FN_SET, 22'd5, 16'd0, '1);
    add_call(tkv_pkg::FN_GET, 22'd5, 16'd0, '0);
    add_call(tkv_pkg::FN_SET, 22'h3FFFFF, tkv_pkg::KEY_IN_W'(tkv_pkg::KEY_COUNT - 1),
             64'h0123_4567_89AB_CDEF);
    add_call(tkv_pkg::FN_GET, 22'h3FFFFF, tkv_pkg::KEY_IN_W'(tkv_pkg::KEY_COUNT - 1), '0);
    add_call(tkv_pkg::FN_GET, 22'd0, tkv_pkg::KEY_IN_W'(tkv_pkg::KEY_COUNT - 1), '0);
    add_call(tkv_pkg::FN_SET, 22'd0, 16'd3, 64'hFEDC_BA98_7654_3210);
    add_call(tkv_pkg::FN_GET, 22'd0, 16'd3, '0);
    add_call(tkv_pkg::FN_GET, 22'd7, 16'd3, '0);
    add_call(tkv_pkg::FN_SET, 22'd9, tkv_pkg::KEY_IN_W'(tkv_pkg::KEY_COUNT), '1);
    add_call(tkv_pkg::FN_GET, 22'd9, 16'hFFFF, '0);
    add_call(tkv_pkg::FN_DELETE, 22'd0, 16'hFFFF, '0);
    add_call(tkv_pkg::FN_DELETE, 22'd0, 16'd0, '0);
    add_call(tkv_pkg::FN_GET, 22'd5, 16'd0, '0);
    add_call(tkv_pkg::FN_DELETE, 22'd0, tkv_pkg::KEY_IN_W'(tkv_pkg::KEY_COUNT - 1), '0);
    add_call(tkv_pkg::FN_GET, 22'h3FFFFF, tkv_pkg::KEY_IN_W'(tkv_pkg::KEY_COUNT - 1), '0);
    add_call(tkv_pkg::FN_CREATE, 22'h3FFFFF, 16'hFFFF, '1);
    add_call(tkv_pkg::FN_CREATE, 22'd0, 16'd0, '0);

    // A few hot threads revisit their slots; fresh ids keep claiming slots
    // until the table is full and slot zero becomes shared.
    hot_tid[0] = '0;
    for (int i = 1; i < 8; i++) begin
      hot_tid[i] = tkv_pkg::TID_W'($urandom_range((1 << tkv_pkg::TID_W) - 1, 1));
    end

    for (int n = 0; n < 1632; n++) begin
      ph      = n / 408;
      c       = '0;
      c.phase = ph;
      c.drain = (n == 0) || (n == 816);
      roll    = $urandom_range(99);
      if (roll < create_pct[ph]) begin
        c.func = tkv_pkg::FN_CREATE;
      end else if (roll < create_pct[ph] + 4) begin
        c.func = tkv_pkg::FN_DELETE;
      end else begin
        c.func = $urandom_range(1) ? tkv_pkg::FN_SET : tkv_pkg::FN_GET;
      end
      if ($urandom_range(1)) begin
        c.tid = hot_tid[$urandom_range(7)];
      end else begin
        c.tid = tkv_pkg::TID_W'($urandom_range((1 << tkv_pkg::TID_W) - 1));
      end
      kroll = $urandom_range(99);
      if (kroll < 8) begin
        c.key = tkv_pkg::KEY_IN_W'(tkv_pkg::KEY_COUNT
                                   + $urandom_range(65535 - tkv_pkg::KEY_COUNT));
      end else if (kroll < 60) begin
        c.key = tkv_pkg::KEY_IN_W'($urandom_range(5));
      end else if (kroll < 75) begin
        c.key = tkv_pkg::KEY_IN_W'(tkv_pkg::KEY_COUNT - 1 - $urandom_range(3));
      end else begin
        c.key = tkv_pkg::KEY_IN_W'($urandom_range(tkv_pkg::KEY_COUNT - 1));
      end
      case ($urandom_range(9))
        0: c.wval = '0;
        1: c.wval = '1;
        default: c.wval = {$urandom, $urandom};
      endcase
      queued_calls.push_back(c);
    end

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    while (queued_calls.size() != 0 || in_valid) @(posedge clk);
    while (owed_replies.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== thread_key_value_table_core.f =====
design/tkv_pkg.sv
design/tkv_cell.sv
design/thread_key_value_table_core.sv
bench/thread_key_value_table_core_tb.sv
